// ----- rtl/sfl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package sfl_pkg;

    // sample width and default delay line depth
    localparam int SampleW = 16;
    localparam int DefDepth = 2048;

    // configuration register indexes
    localparam logic [2:0] CfgBaseDelay = 3'd0;
    localparam logic [2:0] CfgSweep = 3'd1;
    localparam logic [2:0] CfgPhaseStep = 3'd2;
    localparam logic [2:0] CfgFeedback = 3'd3;
    localparam logic [2:0] CfgWetGain = 3'd4;
    localparam logic [2:0] CfgWaveShape = 3'd5;
    localparam logic [2:0] CfgInterp = 3'd6;
    localparam logic [2:0] CfgInvert = 3'd7;

    // LFO shapes
    localparam logic [1:0] WaveSine = 2'd0;
    localparam logic [1:0] WaveTri = 2'd1;
    localparam logic [1:0] WaveSquare = 2'd2;
    localparam logic [1:0] WaveSaw = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic       ld_in;
        logic       lfo;
        logic       dly;
        logic       pos;
        logic       rd;
        logic       cap;
        logic [1:0] tap_k;
        logic       ch;
        logic       coef;
        logic       horn;
        logic [1:0] hstep;
        logic       lin;
        logic       wet;
        logic       fb;
        logic       wr;
        logic       ld_out;
        logic       adv;
    } t_cmd;

    typedef struct packed {
        logic cubic;
    } t_sts;

    // quarter-wave sine, Q15, 17 points
    function automatic logic [14:0] qsin(input logic [4:0] idx);
        logic [14:0] v;
        case (idx)
            5'd0: v = 15'd0;
            5'd1: v = 15'd3212;
            5'd2: v = 15'd6393;
            5'd3: v = 15'd9512;
            5'd4: v = 15'd12539;
            5'd5: v = 15'd15446;
            5'd6: v = 15'd18204;
            5'd7: v = 15'd20787;
            5'd8: v = 15'd23170;
            5'd9: v = 15'd25329;
            5'd10: v = 15'd27245;
            5'd11: v = 15'd28898;
            5'd12: v = 15'd30273;
            5'd13: v = 15'd31356;
            5'd14: v = 15'd32137;
            5'd15: v = 15'd32609;
            default: v = 15'd32767;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/sfl_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module sfl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ----- rtl/sfl_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module sfl_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    input  wire sfl_pkg::t_sts i_sts,
    output sfl_pkg::t_cmd      o_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_LFO  = 4'd1;
    localparam logic [3:0] S_DLY  = 4'd2;
    localparam logic [3:0] S_POS  = 4'd3;
    localparam logic [3:0] S_RADR = 4'd4;
    localparam logic [3:0] S_RDAT = 4'd5;
    localparam logic [3:0] S_COEF = 4'd6;
    localparam logic [3:0] S_HORN = 4'd7;
    localparam logic [3:0] S_LIN  = 4'd8;
    localparam logic [3:0] S_WET  = 4'd9;
    localparam logic [3:0] S_FB   = 4'd10;
    localparam logic [3:0] S_WR   = 4'd11;
    localparam logic [3:0] S_DONE = 4'd12;

    logic [3:0] r_state, n_state;
    logic [1:0] r_k, n_k;
    logic [1:0] r_h, n_h;
    logic       r_ch, n_ch;
    logic       r_ovld, n_ovld;
    logic       w_ld_out;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovld;
    assign w_ld_out    = (r_state == S_DONE) && (!r_ovld || i_out_ready);

    // next state and counters
    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_h     = r_h;
        n_ch    = r_ch;
        case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_LFO;
            S_LFO:  n_state = S_DLY;
            S_DLY:  n_state = S_POS;
            S_POS: begin
                n_state = S_RADR;
                n_k     = 2'd0;
                n_ch    = 1'b0;
            end
            S_RADR: n_state = S_RDAT;
            S_RDAT: begin
                if (r_k == 2'd3) begin
                    n_state = i_sts.cubic ? S_COEF : S_LIN;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = S_RADR;
                end
            end
            S_COEF: begin
                n_state = S_HORN;
                n_h     = 2'd0;
            end
            S_HORN: begin
                if (r_h == 2'd2) n_state = S_WET;
                else n_h = r_h + 2'd1;
            end
            S_LIN: n_state = S_WET;
            S_WET: n_state = S_FB;
            S_FB:  n_state = S_WR;
            S_WR: begin
                if (r_ch) begin
                    n_state = S_DONE;
                end else begin
                    n_ch    = 1'b1;
                    n_k     = 2'd0;
                    n_state = S_RADR;
                end
            end
            S_DONE: if (w_ld_out) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // output beat holding
    always_comb begin
        n_ovld = r_ovld;
        if (r_ovld && i_out_ready) n_ovld = 1'b0;
        if (w_ld_out) n_ovld = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= 2'd0;
            r_h     <= 2'd0;
            r_ch    <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_h     <= n_h;
            r_ch    <= n_ch;
            r_ovld  <= n_ovld;
        end
    end

    // command decode
    always_comb begin
        o_cmd        = '0;
        o_cmd.ld_in  = (r_state == S_IDLE) && i_in_valid;
        o_cmd.lfo    = (r_state == S_LFO);
        o_cmd.dly    = (r_state == S_DLY);
        o_cmd.pos    = (r_state == S_POS);
        o_cmd.rd     = (r_state == S_RADR);
        o_cmd.cap    = (r_state == S_RDAT);
        o_cmd.tap_k  = r_k;
        o_cmd.ch     = r_ch;
        o_cmd.coef   = (r_state == S_COEF);
        o_cmd.horn   = (r_state == S_HORN);
        o_cmd.hstep  = r_h;
        o_cmd.lin    = (r_state == S_LIN);
        o_cmd.wet    = (r_state == S_WET);
        o_cmd.fb     = (r_state == S_FB);
        o_cmd.wr     = (r_state == S_WR);
        o_cmd.ld_out = w_ld_out;
        o_cmd.adv    = w_ld_out;
    end

endmodule
`default_nettype wire

// ----- rtl/sfl_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
module sfl_dp #(
    parameter int DEPTH = sfl_pkg::DefDepth
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire sfl_pkg::t_cmd i_cmd,
    output sfl_pkg::t_sts      o_sts,
    input  wire logic          i_cfg_we,
    input  wire logic [2:0]    i_cfg_idx,
    input  wire logic [23:0]   i_cfg_data,
    input  wire logic [31:0]   i_in_data,
    output logic      [31:0]   o_out_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int PW = AW + 8;

    // configuration
    logic [18:0] r_base, r_sweep;
    logic [23:0] r_pstep;
    logic [14:0] r_fbg, r_wetg;
    logic [1:0]  r_shape;
    logic        r_cubic, r_inv;

    // item state
    logic [AW-1:0] r_wi;
    logic [AW:0]   r_fill;
    logic [23:0]   r_phase;

    // per item working registers
    logic signed [15:0] r_in_l, r_in_r;
    logic [16:0]        r_lfo;
    logic [20:0]        r_dly;
    logic [AW-1:0]      r_idx;
    logic [7:0]         r_frac;
    logic               r_rd_vld;
    logic signed [15:0] r_x [4];
    logic signed [20:0] r_b0, r_b1, r_b2;
    logic signed [47:0] r_acc;
    logic signed [25:0] r_lin;
    logic signed [24:0] r_wet, r_fbv;
    logic signed [15:0] r_res_l, r_res_r;
    logic [15:0]        r_out_l, r_out_r;

    logic [AW-1:0] w_raddr;
    logic [15:0]   w_rd_l, w_rd_r;
    logic [15:0]   w_wdata;
    logic          w_we_l, w_we_r;

    function automatic logic signed [15:0] sat16(input logic signed [26:0] v);
        logic signed [15:0] r;
        if (v > 27'sd32767) r = 16'sh7fff;
        else if (v < -27'sd32768) r = 16'sh8000;
        else r = v[15:0];
        return r;
    endfunction

    assign o_sts.cubic = r_cubic;
    assign o_out_data  = {r_out_r, r_out_l};

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= 19'd184320;
            r_sweep <= 19'd61440;
            r_pstep <= 24'd350;
            r_fbg   <= 15'd16384;
            r_wetg  <= 15'd32767;
            r_shape <= sfl_pkg::WaveSine;
            r_cubic <= 1'b0;
            r_inv   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sfl_pkg::CfgBaseDelay: r_base  <= i_cfg_data[18:0];
                sfl_pkg::CfgSweep:     r_sweep <= i_cfg_data[18:0];
                sfl_pkg::CfgPhaseStep: r_pstep <= i_cfg_data;
                sfl_pkg::CfgFeedback:  r_fbg   <= i_cfg_data[14:0];
                sfl_pkg::CfgWetGain:   r_wetg  <= i_cfg_data[14:0];
                sfl_pkg::CfgWaveShape: r_shape <= i_cfg_data[1:0];
                sfl_pkg::CfgInterp:    r_cubic <= i_cfg_data[0];
                sfl_pkg::CfgInvert:    r_inv   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // write pointer, fill count, LFO phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wi    <= '0;
            r_fill  <= '0;
            r_phase <= '0;
        end else if (i_cmd.adv) begin
            r_wi    <= r_wi + AW'(1);
            r_phase <= r_phase + r_pstep;
            if (r_fill != (AW+1)'(DEPTH)) r_fill <= r_fill + (AW+1)'(1);
        end
    end

    // LFO level
    logic [1:0]  w_q;
    logic [21:0] w_in;
    logic [22:0] w_spos;
    logic [4:0]  w_seg;
    logic [14:0] w_tlo, w_thi, w_s;
    logic [32:0] w_sprod;
    logic [16:0] w_lfo;
    always_comb begin
        w_q     = r_phase[23:22];
        w_in    = r_phase[21:0];
        w_spos  = w_q[0] ? (23'h400000 - {1'b0, w_in}) : {1'b0, w_in};
        w_seg   = w_spos[22:18];
        w_tlo   = sfl_pkg::qsin(w_seg);
        w_thi   = sfl_pkg::qsin(w_seg + 5'd1);
        w_sprod = 33'(w_thi - w_tlo) * 33'(w_spos[17:0]);
        w_s     = w_seg[4] ? 15'd32767 : w_tlo + w_sprod[32:18];
        case (r_shape)
            sfl_pkg::WaveSine:
                w_lfo = w_q[1] ? 17'd32768 - 17'(w_s) : 17'd32768 + 17'(w_s);
            sfl_pkg::WaveTri: begin
                if (r_phase < 24'h400000)
                    w_lfo = 17'd32768 + 17'(r_phase[23:7]);
                else if (r_phase < 24'hC00000)
                    w_lfo = 17'd65536 - 17'((r_phase - 24'h400000) >> 7);
                else
                    w_lfo = 17'((r_phase - 24'hC00000) >> 7);
            end
            sfl_pkg::WaveSquare:
                w_lfo = r_phase[23] ? 17'd0 : 17'd65536;
            default:
                w_lfo = r_phase[23] ? 17'(r_phase[22:8]) : 17'd32768 + 17'(r_phase[22:8]);
        endcase
    end

    // delay and read position
    logic [35:0] w_dprod;
    logic [31:0] w_pos;
    assign w_dprod = 36'(r_sweep) * 36'(r_lfo);
    assign w_pos   = 32'({r_wi, 8'h00}) - 32'(r_dly) - 32'd768;
    assign w_raddr = r_idx + AW'(i_cmd.tap_k) - AW'(1);

    // interpolation, wet, feedback and output arithmetic
    logic signed [20:0] w_x0, w_x1, w_x2, w_x3;
    logic signed [8:0]  w_f;
    logic signed [39:0] w_ha;
    logic signed [47:0] w_hadd, w_hnext;
    logic signed [47:0] w_cr;
    logic signed [25:0] w_lr;
    logic signed [23:0] w_tap;
    logic signed [39:0] w_wprod, w_fprod;
    logic signed [15:0] w_in_ch;
    logic signed [26:0] w_out_sum, w_st_sum;
    always_comb begin
        w_x0 = 21'(r_x[0]);
        w_x1 = 21'(r_x[1]);
        w_x2 = 21'(r_x[2]);
        w_x3 = 21'(r_x[3]);
        w_f  = $signed({1'b0, r_frac});
        case (i_cmd.hstep)
            2'd0: begin
                w_ha   = 40'(r_b0);
                w_hadd = 48'(r_b1) <<< 8;
            end
            2'd1: begin
                w_ha   = r_acc[39:0];
                w_hadd = 48'(r_b2) <<< 16;
            end
            default: begin
                w_ha   = r_acc[39:0];
                w_hadd = 48'(w_x1) <<< 25;
            end
        endcase
        w_hnext   = 48'(w_ha * 49'(w_f)) + w_hadd;
        w_cr      = (r_acc + 48'sd16777216) >>> 25;
        w_lr      = (r_lin + 26'sd128) >>> 8;
        w_tap     = r_cubic ? w_cr[23:0] : 24'(w_lr);
        w_wprod   = 40'($signed({1'b0, r_wetg})) * 40'(w_tap);
        w_fprod   = 40'($signed({1'b0, r_fbg})) * 40'(w_tap);
        w_in_ch   = i_cmd.ch ? r_in_r : r_in_l;
        w_out_sum = r_inv ? 27'(w_in_ch) - 27'(r_wet) : 27'(w_in_ch) + 27'(r_wet);
        w_st_sum  = 27'(w_in_ch) + 27'(r_fbv);
        w_wdata   = sat16(w_st_sum);
    end

    assign w_we_l = i_cmd.wr && !i_cmd.ch;
    assign w_we_r = i_cmd.wr && i_cmd.ch;

    // working registers
    logic signed [39:0] w_wr_rnd, w_fb_rnd;
    assign w_wr_rnd = (w_wprod + 40'sd16384) >>> 15;
    assign w_fb_rnd = (w_fprod + 40'sd16384) >>> 15;

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_in) begin
            r_in_l <= i_in_data[15:0];
            r_in_r <= i_in_data[31:16];
        end
        if (i_cmd.lfo) r_lfo <= w_lfo;
        if (i_cmd.dly) r_dly <= 21'(r_base) + 21'(w_dprod[35:16]);
        if (i_cmd.pos) begin
            r_idx  <= w_pos[PW-1:8];
            r_frac <= w_pos[7:0];
        end
        if (i_cmd.rd) r_rd_vld <= ({1'b0, w_raddr} < r_fill);
        if (i_cmd.cap) begin
            if (!r_rd_vld) r_x[i_cmd.tap_k] <= '0;
            else r_x[i_cmd.tap_k] <= i_cmd.ch ? w_rd_r : w_rd_l;
        end
        if (i_cmd.coef) begin
            r_b0 <= 21'(-w_x0 + 3 * w_x1 - 3 * w_x2 + w_x3);
            r_b1 <= 21'(2 * w_x0 - 5 * w_x1 + 4 * w_x2 - w_x3);
            r_b2 <= w_x2 - w_x0;
        end
        if (i_cmd.horn) r_acc <= w_hnext;
        if (i_cmd.lin) begin
            r_lin <= 26'($signed({1'b0, 9'd256 - {1'b0, r_frac}})) * 26'(r_x[1])
                   + 26'(w_f) * 26'(r_x[2]);
        end
        if (i_cmd.wet) r_wet <= w_wr_rnd[24:0];
        if (i_cmd.fb) r_fbv <= w_fb_rnd[24:0];
        if (i_cmd.wr) begin
            if (i_cmd.ch) r_res_r <= sat16(w_out_sum);
            else r_res_l <= sat16(w_out_sum);
        end
        if (i_cmd.ld_out) begin
            r_out_l <= r_res_l;
            r_out_r <= r_res_r;
        end
    end

    // delay lines
    sfl_ram #(.WIDTH(sfl_pkg::SampleW), .DEPTH(DEPTH)) u_ram_l (
        .i_clk   (i_clk),
        .i_we    (w_we_l),
        .i_waddr (r_wi),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_l)
    );

    sfl_ram #(.WIDTH(sfl_pkg::SampleW), .DEPTH(DEPTH)) u_ram_r (
        .i_clk   (i_clk),
        .i_we    (w_we_r),
        .i_waddr (r_wi),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_r)
    );

endmodule
`default_nettype wire

// ----- rtl/stereo_flanger_lfo_delay.sv -----
`timescale 1ns / 1ps
`default_nettype none
// channel   dir  handshake                         payload
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready   left_in, right_in
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready   left_out, right_out
// cfg       in   i_cfg_we                          i_cfg_idx, i_cfg_data
//
// A beat steps through LFO level, delay and read position, then per channel
// through four tap reads from the single read port of its line, linear or
// cubic interpolation, wet, feedback and write, and then loads its result;
// the next beat is accepted only back in idle. Reset is synchronous; the
// lines read as zero until written, tracked by a fill count, so no clearing
// pass. A stalled output holds the last step until the result register frees.
// DEPTH must be a power of two.
module stereo_flanger_lfo_delay #(
    parameter int DEPTH = sfl_pkg::DefDepth
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,  // left_in [15:0], right_in [31:16]
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic      [31:0] o_m_axis_tdata,  // left_out [15:0], right_out [31:16]
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [23:0] i_cfg_data
);

    sfl_pkg::t_cmd w_cmd;
    sfl_pkg::t_sts w_sts;

    sfl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    sfl_dp #(.DEPTH(DEPTH)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_data  (i_s_axis_tdata),
        .o_out_data (o_m_axis_tdata)
    );

    // a loaded result is offered next cycle
    a_ld_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.ld_out |=> o_m_axis_tvalid) else $error("result not offered");

    // one item at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("second item accepted");

    // datapath steps never overlap
    a_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.lfo, w_cmd.dly, w_cmd.pos, w_cmd.rd, w_cmd.cap, w_cmd.coef,
                  w_cmd.horn, w_cmd.lin, w_cmd.wet, w_cmd.fb, w_cmd.wr}))
        else $error("overlapping datapath steps");

endmodule
`default_nettype wire

// ----- tb/stereo_flanger_lfo_delay_chk.sv -----
`timescale 1ns / 1ps
module stereo_flanger_lfo_delay_chk (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_vld,
    input  logic        i_in_rdy,
    input  logic [31:0] i_in_data,
    input  logic        i_out_vld,
    input  logic        i_out_rdy,
    input  logic [31:0] i_out_data,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);

    localparam int Depth = 2048;
    localparam int Span = Depth * 256;

    logic signed [15:0] left_line [Depth];
    logic signed [15:0] right_line [Depth];
    int unsigned wr_ptr;
    logic [23:0] phase;

    logic [18:0] base_q8, sweep_q8;
    logic [23:0] step_q24;
    logic [14:0] fb_q15, wet_q15;
    logic [1:0]  shape;
    logic        cubic, invert;

    logic [31:0] flanged_q[$];

    const int unsigned sine_pts[17] = '{0, 3212, 6393, 9512, 12539, 15446, 18204,
        20787, 23170, 25329, 27245, 28898, 30273, 31356, 32137, 32609, 32767};

    // half-LSB-up rounding with floor
    function automatic longint rnd_shr(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint unsigned sine_quarter(int unsigned pos);
        int unsigned seg, fr;
        seg = pos >> 18;
        fr = pos & 32'h3FFFF;
        if (seg >= 16) return sine_pts[16];
        return sine_pts[seg] +
            ((longint'(sine_pts[seg + 1] - sine_pts[seg]) * fr) >> 18);
    endfunction

    function automatic longint unsigned lfo_of(int unsigned p);
        int unsigned q, r;
        longint unsigned s;
        case (shape)
            sfl_pkg::WaveSine: begin
                q = p >> 22;
                r = p & 32'h3FFFFF;
                s = q[0] ? sine_quarter(32'h400000 - r) : sine_quarter(r);
                return (q < 2) ? 32768 + s : 32768 - s;
            end
            sfl_pkg::WaveTri: begin
                if (p < 32'h400000) return 32768 + (p >> 7);
                if (p < 32'hC00000) return 65536 - ((p - 32'h400000) >> 7);
                return (p - 32'hC00000) >> 7;
            end
            sfl_pkg::WaveSquare: return (p < 32'h800000) ? 65536 : 0;
            default: return (p < 32'h800000) ? 32768 + (p >> 8) : (p - 32'h800000) >> 8;
        endcase
    endfunction

    function automatic longint tap_of(bit is_left, int unsigned idx, longint f);
        longint x0, x1, x2, x3, b0, b1, b2, acc;
        if (is_left) begin
            x0 = left_line[(idx + Depth - 1) % Depth]; x1 = left_line[idx];
            x2 = left_line[(idx + 1) % Depth]; x3 = left_line[(idx + 2) % Depth];
        end else begin
            x0 = right_line[(idx + Depth - 1) % Depth]; x1 = right_line[idx];
            x2 = right_line[(idx + 1) % Depth]; x3 = right_line[(idx + 2) % Depth];
        end
        if (!cubic) return rnd_shr((256 - f) * x1 + f * x2, 8);
        b0 = -x0 + 3 * x1 - 3 * x2 + x3;
        b1 = 2 * x0 - 5 * x1 + 4 * x2 - x3;
        b2 = x2 - x0;
        acc = b0;
        acc = acc * f + b1 * 256;
        acc = acc * f + b2 * 65536;
        acc = acc * f + x1 * 2 * 16777216;
        return rnd_shr(acc, 25);
    endfunction

    // one stereo beat through the flanger model
    task automatic flange_beat(input logic [31:0] din);
        longint unsigned lvl, dly, off, pos;
        int unsigned idx;
        longint f, tl, tr, wl, wr, inl, inr, ol, orr;
        lvl = lfo_of(phase);
        dly = base_q8 + ((longint'(sweep_q8) * lvl) >> 16);
        off = ((dly % Span) + 768) % Span;
        pos = ((longint'(wr_ptr) * 256) + Span - off) % Span;
        idx = pos >> 8;
        f = pos & 255;
        inl = $signed(din[15:0]);
        inr = $signed(din[31:16]);
        tl = tap_of(1, idx, f);
        tr = tap_of(0, idx, f);
        wl = rnd_shr(longint'(wet_q15) * tl, 15);
        wr = rnd_shr(longint'(wet_q15) * tr, 15);
        left_line[wr_ptr] = clip16(inl + rnd_shr(longint'(fb_q15) * tl, 15));
        right_line[wr_ptr] = clip16(inr + rnd_shr(longint'(fb_q15) * tr, 15));
        ol = clip16(invert ? inl - wl : inl + wl);
        orr = clip16(invert ? inr - wr : inr + wr);
        flanged_q.insert(flanged_q.size(), {orr[15:0], ol[15:0]});
        wr_ptr = (wr_ptr + 1) % Depth;
        phase = phase + step_q24;
    endtask

    always @(posedge i_clk) begin
        logic [31:0] want;
        if (!i_rst_n) begin
            for (int k = 0; k < Depth; k++) begin
                left_line[k] = 0;
                right_line[k] = 0;
            end
            wr_ptr = 0; phase = 0;
            base_q8 = 184320; sweep_q8 = 61440; step_q24 = 350;
            fb_q15 = 16384; wet_q15 = 32767; shape = sfl_pkg::WaveSine;
            cubic = 0; invert = 0;
            flanged_q.delete();
            o_errors = 0;
            o_pending = 0;
        end else begin
            // compare first, then take the new beat
            if (i_out_vld && i_out_rdy) begin
                if (flanged_q.size() == 0) begin
                    $display("%0t: unexpected beat %h", $time, i_out_data);
                    o_errors = o_errors + 1;
                end else begin
                    want = flanged_q.pop_front();
                    if (want[15:0] !== i_out_data[15:0]) begin
                        $display("%0t: left_out expected %h got %h", $time,
                                 want[15:0], i_out_data[15:0]);
                        o_errors = o_errors + 1;
                    end
                    if (want[31:16] !== i_out_data[31:16]) begin
                        $display("%0t: right_out expected %h got %h", $time,
                                 want[31:16], i_out_data[31:16]);
                        o_errors = o_errors + 1;
                    end
                end
            end
            if (i_in_vld && i_in_rdy) flange_beat(i_in_data);
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    sfl_pkg::CfgBaseDelay: base_q8 = i_cfg_data[18:0];
                    sfl_pkg::CfgSweep:     sweep_q8 = i_cfg_data[18:0];
                    sfl_pkg::CfgPhaseStep: step_q24 = i_cfg_data;
                    sfl_pkg::CfgFeedback:  fb_q15 = i_cfg_data[14:0];
                    sfl_pkg::CfgWetGain:   wet_q15 = i_cfg_data[14:0];
                    sfl_pkg::CfgWaveShape: shape = i_cfg_data[1:0];
                    sfl_pkg::CfgInterp:    cubic = i_cfg_data[0];
                    sfl_pkg::CfgInvert:    invert = i_cfg_data[0];
                    default: ;
                endcase
            end
            o_pending = flanged_q.size();
        end
    end
endmodule

// ----- tb/stereo_flanger_lfo_delay_tb.sv -----
`timescale 1ns / 1ps
module stereo_flanger_lfo_delay_tb;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_vld = 0;
    logic        s_rdy;
    logic [31:0] s_data = 0;
    logic        m_vld;
    logic        m_rdy = 0;
    logic [31:0] m_data;
    logic        cfg_we = 0;
    logic [2:0]  cfg_idx = 0;
    logic [23:0] cfg_data = 0;
    int          errors, pending;
    int          send_idle = 0, recv_stall = 0;
    longint      cycles = 0;

    always #10 i_clk = ~i_clk;

    stereo_flanger_lfo_delay dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_vld), .o_s_axis_tready(s_rdy), .i_s_axis_tdata(s_data),
        .o_m_axis_tvalid(m_vld), .i_m_axis_tready(m_rdy), .o_m_axis_tdata(m_data),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    stereo_flanger_lfo_delay_chk chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_vld(s_vld), .i_in_rdy(s_rdy), .i_in_data(s_data),
        .i_out_vld(m_vld), .i_out_rdy(m_rdy), .i_out_data(m_data),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    // receiver stalls at the rate of the current phase
    always @(posedge i_clk) begin
        m_rdy <= ($urandom_range(99) >= recv_stall);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("stereo_flanger_lfo_delay test failed");
            $finish;
        end
    end

    // valid stays up after the beat; the next idle cycle or drain drops it
    task automatic send_beat(input logic [15:0] l, input logic [15:0] r);
        while ($urandom_range(99) < send_idle) begin
            s_vld <= 0;
            @(posedge i_clk);
        end
        s_vld <= 1;
        s_data <= {r, l};
        @(posedge i_clk);
        while (!s_rdy) @(posedge i_clk);
    endtask

    task automatic drain();
        s_vld <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
        cfg_we <= 1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge i_clk);
    endtask

    // one setting of all registers
    task automatic set_all(input logic [18:0] bd, input logic [18:0] sw,
                           input logic [23:0] ps, input logic [14:0] fb,
                           input logic [14:0] wg, input logic [1:0] ws,
                           input logic cu, input logic inv);
        drain();
        write_reg(sfl_pkg::CfgBaseDelay, 24'(bd));
        write_reg(sfl_pkg::CfgSweep, 24'(sw));
        write_reg(sfl_pkg::CfgPhaseStep, ps);
        write_reg(sfl_pkg::CfgFeedback, 24'(fb));
        write_reg(sfl_pkg::CfgWetGain, 24'(wg));
        write_reg(sfl_pkg::CfgWaveShape, 24'(ws));
        write_reg(sfl_pkg::CfgInterp, 24'(cu));
        write_reg(sfl_pkg::CfgInvert, 24'(inv));
        cfg_we <= 0;
    endtask

    task automatic rand_beats(input int n);
        logic [15:0] l, r;
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(3))
                0: begin l = 16'($urandom); r = 16'($urandom); end
                1: begin l = $urandom_range(1) ? 16'h7FFF : 16'h8000; r = ~l; end
                default: begin
                    l = 16'($urandom_range(4000) - 2000);
                    r = 16'($urandom_range(4000));
                end
            endcase
            send_beat(l, r);
        end
    endtask

    task automatic rand_setting();
        set_all(19'($urandom_range(1) ? $urandom_range(4000) : $urandom_range(522240)),
                19'($urandom_range(1) ? $urandom_range(4000) : $urandom_range(522240)),
                24'($urandom_range(1) ? $urandom_range(1 << 20) : $urandom),
                15'($urandom_range(32767)), 15'($urandom_range(32767)),
                2'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: reset settings with sample extremes
        send_beat(16'h7FFF, 16'h8000);
        send_beat(16'h8000, 16'h7FFF);
        send_beat(16'h0000, 16'hFFFF);
        send_beat(16'h0001, 16'h5555);
        // short delay, read meets write, cubic, large feedback, inverted
        set_all(19'd0, 19'd0, 24'hFFFFFF, 15'h7FFF, 15'h7FFF, sfl_pkg::WaveSquare,
                1'b1, 1'b1);
        for (int k = 0; k < 6; k++) send_beat(k[0] ? 16'h7FFF : 16'h8000, 16'hAAAA);
        // long delay wrap, triangle, full sweep
        set_all(19'd522240, 19'd522240, 24'h400000, 15'd32440, 15'd0, sfl_pkg::WaveTri,
                1'b0, 1'b0);
        for (int k = 0; k < 5; k++) send_beat(16'h1234, 16'hEDCB);
        set_all(19'd1000, 19'd522240, 24'h123456, 15'd100, 15'd32767, sfl_pkg::WaveSaw,
                1'b1, 1'b0);
        for (int k = 0; k < 5; k++) send_beat(16'h7FFF, 16'h8000);
        // unknown index has no slot: all eight are covered above

        // random phases with different idling
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle = 0; recv_stall = 0; end
                1: begin send_idle = 87; recv_stall = 0; end
                2: begin send_idle = 0; recv_stall = 87; end
                default: begin send_idle = 29; recv_stall = 29; end
            endcase
            rand_setting();
            rand_beats(25);
            drain();
            rand_beats(25);
        end
        send_idle = 0; recv_stall = 0;

        drain();
        if (errors == 0)
            $display("stereo_flanger_lfo_delay test passed");
        else
            $display("stereo_flanger_lfo_delay test failed");
        $finish;
    end
endmodule
